// File: sv/c8_pkg.sv
package c8_pkg;

   localparam int MEM_BYTES     = 4096;
   localparam int ADDR_W        = $clog2(MEM_BYTES);
   localparam int STACK_DEPTH   = 16;
   localparam int SP_W          = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W         = $clog2(STACK_DEPTH + 1);
   localparam int SCREEN_WIDTH  = 64;
   localparam int SCREEN_HEIGHT = 32;
   localparam int COL_W         = $clog2(SCREEN_WIDTH);
   localparam int ROW_W         = $clog2(SCREEN_HEIGHT);
   localparam int FONT_BYTES    = 80;

   localparam logic [ADDR_W-1:0] START_ADDR = 12'h200;

   localparam logic [7:0] FONT [FONT_BYTES] = '{
      8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
   };

   localparam logic [1:0] FN_LOAD = 2'd0;
   localparam logic [1:0] FN_EXEC = 2'd1;
   localparam logic [1:0] FN_TICK = 2'd2;
   localparam logic [1:0] FN_ROW  = 2'd3;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_HALT  = 3'd1;
   localparam logic [2:0] ST_OVF   = 3'd2;
   localparam logic [2:0] ST_UNDEF = 3'd3;
   localparam logic [2:0] ST_WAIT  = 3'd4;

   typedef logic [2:0] alu_op_type;

   localparam alu_op_type ALU_ADD   = 3'd0;
   localparam alu_op_type ALU_SUB   = 3'd1;
   localparam alu_op_type ALU_OR    = 3'd2;
   localparam alu_op_type ALU_AND   = 3'd3;
   localparam alu_op_type ALU_XOR   = 3'd4;
   localparam alu_op_type ALU_SHR   = 3'd5;
   localparam alu_op_type ALU_SHL   = 3'd6;
   localparam alu_op_type ALU_PASSB = 3'd7;

   typedef struct packed {
      alu_op_type op;
      logic [7:0] a;
      logic [7:0] b;
   } alu_req_type;

   typedef struct packed {
      logic [7:0] res;
      logic       flag;
   } alu_rsp_type;

   // Hundreds, tens and ones of a byte, each in four bits.
   function automatic logic [11:0] bcd_digits(input logic [7:0] v);
      logic [7:0]  rem;
      logic [1:0]  h;
      logic [15:0] prod;
      logic [3:0]  t;
      logic [7:0]  o;
      if (v >= 8'd200) begin
         h   = 2'd2;
         rem = v - 8'd200;
      end else if (v >= 8'd100) begin
         h   = 2'd1;
         rem = v - 8'd100;
      end else begin
         h   = 2'd0;
         rem = v;
      end
      // Multiply by 205/2048 gives the exact tenth for values below 100.
      prod = {8'd0, rem} * 16'd205;
      t    = prod[14:11];
      o    = rem - {1'b0, t, 3'b000} - {3'b000, t, 1'b0};
      return {2'b00, h, t, o[3:0]};
   endfunction

endpackage

// File: sv/c8_ram.sv
module c8_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/c8_alu.sv
module c8_alu (
   input  c8_pkg::alu_req_type req,
   output c8_pkg::alu_rsp_type rsp
);
   import c8_pkg::*;

   logic [8:0] sum;

   assign sum = {1'b0, req.a} + {1'b0, req.b};

   always_comb begin
      rsp.res  = req.b;
      rsp.flag = 1'b0;
      case (req.op)
         ALU_ADD: begin
            rsp.res  = sum[7:0];
            rsp.flag = sum[8];
         end
         ALU_SUB: begin
            rsp.res  = req.a - req.b;
            rsp.flag = (req.a >= req.b);
         end
         ALU_OR:  rsp.res = req.a | req.b;
         ALU_AND: rsp.res = req.a & req.b;
         ALU_XOR: rsp.res = req.a ^ req.b;
         ALU_SHR: begin
            rsp.res  = {1'b0, req.b[7:1]};
            rsp.flag = req.b[0];
         end
         ALU_SHL: begin
            rsp.res  = {req.b[6:0], 1'b0};
            rsp.flag = req.b[7];
         end
         default: rsp.res = req.b;
      endcase
   end

endmodule

// File: sv/chip8_instruction_core_top.sv
// Load byte and tick go from idle to done, a row read via the row state; an execute
// passes the fetch, operand read and execute states. A draw adds a read and a write
// state per sprite row and the VF write, 8xy4-8xyE add the VF write, clear sweeps
// the frame rows, Fx33 writes each digit and Fx55/Fx65 move one register at a time,
// as memory and registers have one read port each. One item is in work at a time;
// the next is taken once the sequencer is back in idle. Reset is synchronous; then a sweep
// loads the font, clears memory, registers and display; no item is taken until it ends.
module chip8_instruction_core_top (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_func,
   input  logic [c8_pkg::ADDR_W-1:0] req_address,
   input  logic [7:0]                req_load_data,
   input  logic [15:0]               req_keys_held,
   input  logic                      req_key_down_valid,
   input  logic [3:0]                req_key_down_code,
   input  logic [7:0]                req_random_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [2:0]                rsp_status,
   output logic [c8_pkg::ADDR_W-1:0] rsp_program_counter,
   output logic                      rsp_sound_on,
   output logic [c8_pkg::SCREEN_WIDTH-1:0] rsp_display_row,
   input  logic                      csr_write_enable,
   input  logic [c8_pkg::ADDR_W-1:0] csr_write_data
);
   import c8_pkg::*;

   localparam logic [4:0] S_INIT    = 5'd0;
   localparam logic [4:0] S_IDLE    = 5'd1;
   localparam logic [4:0] S_ROW     = 5'd2;
   localparam logic [4:0] S_FETCH0  = 5'd3;
   localparam logic [4:0] S_FETCH1  = 5'd4;
   localparam logic [4:0] S_FETCH2  = 5'd5;
   localparam logic [4:0] S_RDX     = 5'd6;
   localparam logic [4:0] S_RDY     = 5'd7;
   localparam logic [4:0] S_EXEC    = 5'd8;
   localparam logic [4:0] S_VF      = 5'd9;
   localparam logic [4:0] S_CLS     = 5'd10;
   localparam logic [4:0] S_DRAW_RD = 5'd11;
   localparam logic [4:0] S_DRAW_WR = 5'd12;
   localparam logic [4:0] S_DRAWF   = 5'd13;
   localparam logic [4:0] S_BCD     = 5'd14;
   localparam logic [4:0] S_ST_RD   = 5'd15;
   localparam logic [4:0] S_ST_WR   = 5'd16;
   localparam logic [4:0] S_LD_RD   = 5'd17;
   localparam logic [4:0] S_LD_WR   = 5'd18;
   localparam logic [4:0] S_DONE    = 5'd19;

   logic [4:0]        state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [ADDR_W-1:0] pc_ff, pc_in;
   logic [ADDR_W-1:0] i_ff, i_in;
   logic [7:0]        dt_ff, dt_in;
   logic [7:0]        snd_ff, snd_in;
   logic [CNT_W-1:0]  sp_ff, sp_in;
   logic              halted_ff, halted_in;
   logic [15:0]       op_ff, op_in;
   logic [7:0]        vx_ff, vx_in;
   logic [7:0]        vy_ff, vy_in;
   logic              flag_ff, flag_in;
   logic              hit_ff, hit_in;
   logic [ROW_W-1:0]  row_ptr_ff, row_ptr_in;
   logic [2:0]        status_ff, status_in;
   logic [SCREEN_WIDTH-1:0] row_ff, row_in;
   logic [15:0]       keys_ff, keys_in;
   logic              kdv_ff, kdv_in;
   logic [3:0]        kcode_ff, kcode_in;
   logic [7:0]        rand_ff, rand_in;
   logic [ADDR_W-1:0] stack_ff [STACK_DEPTH];
   logic              stack_we;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0] rsp_pc_ff, rsp_pc_in;
   logic              rsp_sound_ff, rsp_sound_in;
   logic [SCREEN_WIDTH-1:0] rsp_row_ff, rsp_row_in;

   logic              m_we;
   logic [ADDR_W-1:0] m_waddr, m_raddr;
   logic [7:0]        m_wdata, m_rdata;
   logic              r_we;
   logic [3:0]        r_waddr, r_raddr;
   logic [7:0]        r_wdata, r_rdata;
   logic              f_we;
   logic [ROW_W-1:0]  f_waddr, f_raddr;
   logic [SCREEN_WIDTH-1:0] f_wdata, f_rdata;

   alu_req_type       alu_req;
   alu_rsp_type       alu_rsp;

   logic [7:0]        kk;
   logic [ADDR_W-1:0] nnn;
   logic [3:0]        nib;
   logic [3:0]        xr;
   logic [ADDR_W-1:0] pc_plus2;
   logic [ADDR_W-1:0] i_plus_cnt;
   logic [CNT_W-1:0]  sp_dec;
   logic [SCREEN_WIDTH-1:0] sprite, mask;
   logic [11:0]       digits;
   logic              held;

   assign kk         = op_ff[7:0];
   assign nnn        = op_ff[ADDR_W-1:0];
   assign nib        = op_ff[3:0];
   assign xr         = op_ff[11:8];
   assign pc_plus2   = pc_ff + 12'd2;
   assign i_plus_cnt = i_ff + {8'd0, cnt_ff[3:0]};
   assign sp_dec     = sp_ff - 1'b1;
   assign digits     = bcd_digits(vx_ff);
   assign held       = keys_ff[vx_ff[3:0]];

   // Sprite byte placed at the left edge, then rotated so columns wrap.
   assign sprite = {m_rdata, {(SCREEN_WIDTH-8){1'b0}}};
   assign mask   = (sprite >> vx_ff[COL_W-1:0])
                 | (sprite << (7'd64 - {1'b0, vx_ff[COL_W-1:0]}));

   c8_ram #(.WIDTH(8), .DEPTH(MEM_BYTES)) u_main_mem (
      .clock   (clock),
      .wr_en   (m_we),
      .wr_addr (m_waddr),
      .wr_data (m_wdata),
      .rd_addr (m_raddr),
      .rd_data (m_rdata)
   );

   c8_ram #(.WIDTH(8), .DEPTH(16)) u_regs (
      .clock   (clock),
      .wr_en   (r_we),
      .wr_addr (r_waddr),
      .wr_data (r_wdata),
      .rd_addr (r_raddr),
      .rd_data (r_rdata)
   );

   c8_ram #(.WIDTH(SCREEN_WIDTH), .DEPTH(SCREEN_HEIGHT)) u_frame (
      .clock   (clock),
      .wr_en   (f_we),
      .wr_addr (f_waddr),
      .wr_data (f_wdata),
      .rd_addr (f_raddr),
      .rd_data (f_rdata)
   );

   c8_alu u_alu (
      .req (alu_req),
      .rsp (alu_rsp)
   );

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      pc_in      = pc_ff;
      i_in       = i_ff;
      dt_in      = dt_ff;
      snd_in     = snd_ff;
      sp_in      = sp_ff;
      halted_in  = halted_ff;
      op_in      = op_ff;
      vx_in      = vx_ff;
      vy_in      = vy_ff;
      flag_in    = flag_ff;
      hit_in     = hit_ff;
      row_ptr_in = row_ptr_ff;
      status_in  = status_ff;
      row_in     = row_ff;
      keys_in    = keys_ff;
      kdv_in     = kdv_ff;
      kcode_in   = kcode_ff;
      rand_in    = rand_ff;
      stack_we   = 1'b0;

      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_pc_in     = rsp_pc_ff;
      rsp_sound_in  = rsp_sound_ff;
      rsp_row_in    = rsp_row_ff;

      m_we    = 1'b0;
      m_waddr = i_plus_cnt;
      m_wdata = r_rdata;
      m_raddr = pc_ff;
      r_we    = 1'b0;
      r_waddr = xr;
      r_wdata = alu_rsp.res;
      r_raddr = xr;
      f_we    = 1'b0;
      f_waddr = row_ptr_ff;
      f_wdata = f_rdata ^ mask;
      f_raddr = req_address[ROW_W-1:0];

      alu_req.op = ALU_PASSB;
      alu_req.a  = vx_ff;
      alu_req.b  = vy_ff;

      case (state_ff)
         S_INIT: begin
            m_we    = 1'b1;
            m_waddr = cnt_ff;
            m_wdata = (cnt_ff < 12'(FONT_BYTES)) ? FONT[cnt_ff[6:0]] : 8'd0;
            r_we    = (cnt_ff < 12'd16);
            r_waddr = cnt_ff[3:0];
            r_wdata = 8'd0;
            f_we    = (cnt_ff < 12'(SCREEN_HEIGHT));
            f_waddr = cnt_ff[ROW_W-1:0];
            f_wdata = '0;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == 12'(MEM_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               keys_in   = req_keys_held;
               kdv_in    = req_key_down_valid;
               kcode_in  = req_key_down_code;
               rand_in   = req_random_byte;
               row_in    = '0;
               status_in = halted_ff ? ST_HALT : ST_OK;
               state_in  = S_DONE;
               case (req_func)
                  FN_LOAD: begin
                     m_we    = 1'b1;
                     m_waddr = req_address;
                     m_wdata = req_load_data;
                  end
                  FN_EXEC: begin
                     if (!halted_ff) begin
                        state_in = S_FETCH0;
                     end
                  end
                  FN_TICK: begin
                     if (dt_ff != 8'd0) dt_in = dt_ff - 1'b1;
                     if (snd_ff != 8'd0) snd_in = snd_ff - 1'b1;
                  end
                  default: state_in = S_ROW;
               endcase
            end
         end
         S_ROW: begin
            row_in   = f_rdata;
            state_in = S_DONE;
         end
         S_FETCH0: begin
            m_raddr  = pc_ff;
            state_in = S_FETCH1;
         end
         S_FETCH1: begin
            m_raddr     = pc_ff + 12'd1;
            op_in[15:8] = m_rdata;
            state_in    = S_FETCH2;
         end
         S_FETCH2: begin
            op_in[7:0] = m_rdata;
            pc_in      = pc_plus2;
            r_raddr    = xr;
            state_in   = S_RDX;
         end
         S_RDX: begin
            vx_in    = r_rdata;
            r_raddr  = op_ff[7:4];
            state_in = S_RDY;
         end
         S_RDY: begin
            vy_in    = r_rdata;
            r_raddr  = 4'd0;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_DONE;
            case (op_ff[15:12])
               4'h0: begin
                  if (op_ff == 16'h00E0) begin
                     cnt_in   = '0;
                     state_in = S_CLS;
                  end else if (op_ff == 16'h00EE) begin
                     if (sp_ff == '0) begin
                        halted_in = 1'b1;
                        status_in = ST_HALT;
                     end else begin
                        sp_in = sp_dec;
                        pc_in = stack_ff[sp_dec[SP_W-1:0]];
                     end
                  end else begin
                     status_in = ST_UNDEF;
                  end
               end
               4'h1: pc_in = nnn;
               4'h2: begin
                  // A call on a full stack still jumps; only the push is lost.
                  if (sp_ff != CNT_W'(STACK_DEPTH)) begin
                     stack_we = 1'b1;
                     sp_in    = sp_ff + 1'b1;
                  end else begin
                     status_in = ST_OVF;
                  end
                  pc_in = nnn;
               end
               4'h3: if (vx_ff == kk) pc_in = pc_plus2;
               4'h4: if (vx_ff != kk) pc_in = pc_plus2;
               4'h5: begin
                  if (nib != 4'd0) status_in = ST_UNDEF;
                  else if (vx_ff == vy_ff) pc_in = pc_plus2;
               end
               4'h6: begin
                  r_we    = 1'b1;
                  r_wdata = kk;
               end
               4'h7: begin
                  alu_req.op = ALU_ADD;
                  alu_req.b  = kk;
                  r_we       = 1'b1;
               end
               4'h8: begin
                  r_we     = 1'b1;
                  flag_in  = alu_rsp.flag;
                  state_in = S_VF;
                  case (nib)
                     4'h0: begin
                        alu_req.op = ALU_PASSB;
                        state_in   = S_DONE;
                     end
                     4'h1: begin
                        alu_req.op = ALU_OR;
                        state_in   = S_DONE;
                     end
                     4'h2: begin
                        alu_req.op = ALU_AND;
                        state_in   = S_DONE;
                     end
                     4'h3: begin
                        alu_req.op = ALU_XOR;
                        state_in   = S_DONE;
                     end
                     4'h4: alu_req.op = ALU_ADD;
                     4'h5: alu_req.op = ALU_SUB;
                     4'h6: alu_req.op = ALU_SHR;
                     4'h7: begin
                        alu_req.op = ALU_SUB;
                        alu_req.a  = vy_ff;
                        alu_req.b  = vx_ff;
                     end
                     4'hE: alu_req.op = ALU_SHL;
                     default: begin
                        r_we      = 1'b0;
                        status_in = ST_UNDEF;
                        state_in  = S_DONE;
                     end
                  endcase
               end
               4'h9: begin
                  if (nib != 4'd0) status_in = ST_UNDEF;
                  else if (vx_ff != vy_ff) pc_in = pc_plus2;
               end
               4'hA: i_in = nnn;
               // V0 was read in the previous state and is on the register port now.
               4'hB: pc_in = nnn + {4'd0, r_rdata};
               4'hC: begin
                  r_we    = 1'b1;
                  r_wdata = rand_ff & kk;
               end
               4'hD: begin
                  row_ptr_in = vy_ff[ROW_W-1:0];
                  cnt_in     = '0;
                  hit_in     = 1'b0;
                  state_in   = (nib == 4'd0) ? S_DRAWF : S_DRAW_RD;
               end
               4'hE: begin
                  if (kk == 8'h9E) begin
                     if (held) pc_in = pc_plus2;
                  end else if (kk == 8'hA1) begin
                     if (!held) pc_in = pc_plus2;
                  end else begin
                     status_in = ST_UNDEF;
                  end
               end
               default: begin
                  case (kk)
                     8'h07: begin
                        r_we    = 1'b1;
                        r_wdata = dt_ff;
                     end
                     8'h0A: begin
                        if (kdv_ff) begin
                           r_we    = 1'b1;
                           r_wdata = {4'd0, kcode_ff};
                        end else begin
                           pc_in     = pc_ff - 12'd2;
                           status_in = ST_WAIT;
                        end
                     end
                     8'h15: dt_in = vx_ff;
                     8'h18: snd_in = vx_ff;
                     8'h1E: i_in = i_ff + {4'd0, vx_ff};
                     8'h29: i_in = {6'd0, vx_ff[3:0], 2'b00} + {8'd0, vx_ff[3:0]};
                     8'h33: begin
                        cnt_in   = '0;
                        state_in = S_BCD;
                     end
                     8'h55: begin
                        cnt_in   = '0;
                        state_in = S_ST_RD;
                     end
                     8'h65: begin
                        cnt_in   = '0;
                        state_in = S_LD_RD;
                     end
                     default: status_in = ST_UNDEF;
                  endcase
               end
            endcase
         end
         S_VF: begin
            r_we     = 1'b1;
            r_waddr  = 4'hF;
            r_wdata  = {7'd0, flag_ff};
            state_in = S_DONE;
         end
         S_CLS: begin
            f_we     = 1'b1;
            f_waddr  = cnt_ff[ROW_W-1:0];
            f_wdata  = '0;
            cnt_in   = cnt_ff + 1'b1;
            if (cnt_ff[ROW_W-1:0] == ROW_W'(SCREEN_HEIGHT - 1)) begin
               state_in = S_DONE;
            end
         end
         S_DRAW_RD: begin
            m_raddr  = i_plus_cnt;
            f_raddr  = row_ptr_ff;
            state_in = S_DRAW_WR;
         end
         S_DRAW_WR: begin
            f_we       = 1'b1;
            hit_in     = hit_ff | (|(f_rdata & mask));
            row_ptr_in = row_ptr_ff + 1'b1;
            cnt_in     = cnt_ff + 1'b1;
            state_in   = (cnt_ff[3:0] == nib - 4'd1) ? S_DRAWF : S_DRAW_RD;
         end
         S_DRAWF: begin
            r_we     = 1'b1;
            r_waddr  = 4'hF;
            r_wdata  = {7'd0, hit_ff};
            state_in = S_DONE;
         end
         S_BCD: begin
            m_we   = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            case (cnt_ff[1:0])
               2'd0:    m_wdata = {4'd0, digits[11:8]};
               2'd1:    m_wdata = {4'd0, digits[7:4]};
               default: m_wdata = {4'd0, digits[3:0]};
            endcase
            if (cnt_ff[1:0] == 2'd2) state_in = S_DONE;
         end
         S_ST_RD: begin
            r_raddr  = cnt_ff[3:0];
            state_in = S_ST_WR;
         end
         S_ST_WR: begin
            m_we     = 1'b1;
            m_wdata  = r_rdata;
            cnt_in   = cnt_ff + 1'b1;
            state_in = (cnt_ff[3:0] == xr) ? S_DONE : S_ST_RD;
         end
         S_LD_RD: begin
            m_raddr  = i_plus_cnt;
            state_in = S_LD_WR;
         end
         S_LD_WR: begin
            r_we     = 1'b1;
            r_waddr  = cnt_ff[3:0];
            r_wdata  = m_rdata;
            cnt_in   = cnt_ff + 1'b1;
            state_in = (cnt_ff[3:0] == xr) ? S_DONE : S_LD_RD;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_pc_in     = pc_ff;
               rsp_sound_in  = (snd_ff != 8'd0);
               rsp_row_in    = row_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_write_enable) begin
         pc_in = csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         pc_ff        <= START_ADDR;
         i_ff         <= '0;
         dt_ff        <= '0;
         snd_ff       <= '0;
         sp_ff        <= '0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pc_ff        <= pc_in;
         i_ff         <= i_in;
         dt_ff        <= dt_in;
         snd_ff       <= snd_in;
         sp_ff        <= sp_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      vx_ff         <= vx_in;
      vy_ff         <= vy_in;
      flag_ff       <= flag_in;
      hit_ff        <= hit_in;
      row_ptr_ff    <= row_ptr_in;
      status_ff     <= status_in;
      row_ff        <= row_in;
      keys_ff       <= keys_in;
      kdv_ff        <= kdv_in;
      kcode_ff      <= kcode_in;
      rand_ff       <= rand_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pc_ff     <= rsp_pc_in;
      rsp_sound_ff  <= rsp_sound_in;
      rsp_row_ff    <= rsp_row_in;
      if (stack_we) begin
         stack_ff[sp_ff[SP_W-1:0]] <= pc_ff;
      end
   end

   assign req_stall           = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_program_counter = rsp_pc_ff;
   assign rsp_sound_on        = rsp_sound_ff;
   assign rsp_display_row     = rsp_row_ff;

   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= CNT_W'(STACK_DEPTH))
      else $error("return stack count beyond depth");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      halted_ff |=> halted_ff)
      else $error("halt cleared without reset");

   a_halt_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && halted_ff) |-> (status_ff == ST_HALT))
      else $error("halted core reports a status other than halted");

   a_done_delivers: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && !rsp_stall) |=> (rsp_valid && state_ff == S_IDLE))
      else $error("finished item not moved to the output register");

endmodule

// File: sim/chip8_instruction_core_checker.sv
module chip8_instruction_core_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_func,
   input  logic [11:0] req_address,
   input  logic [7:0]  req_load_data,
   input  logic [15:0] req_keys_held,
   input  logic        req_key_down_valid,
   input  logic [3:0]  req_key_down_code,
   input  logic [7:0]  req_random_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [2:0]  rsp_status,
   input  logic [11:0] rsp_program_counter,
   input  logic        rsp_sound_on,
   input  logic [63:0] rsp_display_row,
   input  logic        csr_write_enable,
   input  logic [11:0] csr_write_data,
   output int          fail_count,
   output int          pending
);
   import c8_pkg::*;

   localparam logic [15:0] OP_CLS = 16'h00E0;
   localparam logic [15:0] OP_RET = 16'h00EE;
   localparam logic [7:0] FX_GET_DELAY = 8'h07, FX_KEY_WAIT = 8'h0A, FX_SET_DELAY = 8'h15,
                          FX_SET_SOUND = 8'h18, FX_ADD_I = 8'h1E, FX_FONT = 8'h29,
                          FX_BCD = 8'h33, FX_STORE = 8'h55, FX_FETCH = 8'h65;
   localparam logic [7:0] EX_SKIP_HELD = 8'h9E, EX_SKIP_FREE = 8'hA1;

   typedef struct packed {
      logic [2:0]  status;
      logic [11:0] pc;
      logic        sound;
      logic [63:0] row;
   } core_result_type;

   core_result_type result_queue[$];

   logic [7:0]  mem [MEM_BYTES];
   logic [7:0]  v [16];
   logic [11:0] idx, pc;
   logic [11:0] stk [STACK_DEPTH];
   int          depth;
   logic [7:0]  delay_t, sound_t;
   logic [63:0] frame [SCREEN_HEIGHT];
   logic        halted;

   task automatic clear_core();
      for (int i = 0; i < MEM_BYTES; i++) mem[i] = (i < FONT_BYTES) ? FONT[i] : 8'h00;
      for (int i = 0; i < 16; i++) v[i] = 8'h00;
      for (int i = 0; i < SCREEN_HEIGHT; i++) frame[i] = '0;
      idx = '0;
      pc = START_ADDR;
      depth = 0;
      delay_t = '0;
      sound_t = '0;
      halted = 1'b0;
   endtask

   task automatic draw(input logic [7:0] px, input logic [7:0] py, input logic [3:0] h);
      logic [5:0]  col, c;
      logic [4:0]  row;
      logic [7:0]  bits;
      logic        hit;
      col = px[5:0];
      row = py[4:0];
      hit = 1'b0;
      for (int r = 0; r < h; r++) begin
         bits = mem[idx + 12'(r)];
         for (int j = 0; j < 8; j++) begin
            if (bits[7-j]) begin
               c = col + 6'(j);
               if (frame[row][63-c]) hit = 1'b1;
               frame[row][63-c] = ~frame[row][63-c];
            end
         end
         row = row + 5'd1;
      end
      v[15] = {7'd0, hit};
   endtask

   task automatic run_instruction(input logic [15:0] keys, input logic kdv,
                                  input logic [3:0] kcode, input logic [7:0] rnd,
                                  output logic [2:0] st);
      logic [15:0] op;
      logic [3:0]  x, y, n;
      logic [7:0]  kk, a, b;
      logic [8:0]  sum;
      logic        f;
      st = ST_OK;
      if (halted) begin
         st = ST_HALT;
         return;
      end
      op = {mem[pc], mem[pc + 12'd1]};
      pc = pc + 12'd2;
      x = op[11:8];
      y = op[7:4];
      n = op[3:0];
      kk = op[7:0];
      a = v[x];
      b = v[y];
      case (op[15:12])
         4'h0: begin
            if (op == OP_CLS) begin
               for (int i = 0; i < SCREEN_HEIGHT; i++) frame[i] = '0;
            end else if (op == OP_RET) begin
               if (depth == 0) begin
                  halted = 1'b1;
                  st = ST_HALT;
               end else begin
                  depth--;
                  pc = stk[depth];
               end
            end else st = ST_UNDEF;
         end
         4'h1: pc = op[11:0];
         4'h2: begin
            if (depth < STACK_DEPTH) begin
               stk[depth] = pc;
               depth++;
            end else st = ST_OVF;
            pc = op[11:0];
         end
         4'h3: if (a == kk) pc = pc + 12'd2;
         4'h4: if (a != kk) pc = pc + 12'd2;
         4'h5: if (n != 0) st = ST_UNDEF; else if (a == b) pc = pc + 12'd2;
         4'h6: v[x] = kk;
         4'h7: v[x] = a + kk;
         4'h8: begin
            case (n)
               4'h0: v[x] = b;
               4'h1: v[x] = a | b;
               4'h2: v[x] = a & b;
               4'h3: v[x] = a ^ b;
               4'h4: begin
                  sum = {1'b0, a} + {1'b0, b};
                  v[x] = sum[7:0];
                  v[15] = {7'd0, sum[8]};
               end
               4'h5: begin f = (a >= b); v[x] = a - b; v[15] = {7'd0, f}; end
               4'h6: begin v[x] = b >> 1; v[15] = {7'd0, b[0]}; end
               4'h7: begin f = (b >= a); v[x] = b - a; v[15] = {7'd0, f}; end
               4'hE: begin v[x] = b << 1; v[15] = {7'd0, b[7]}; end
               default: st = ST_UNDEF;
            endcase
         end
         4'h9: if (n != 0) st = ST_UNDEF; else if (a != b) pc = pc + 12'd2;
         4'hA: idx = op[11:0];
         4'hB: pc = op[11:0] + {4'd0, v[0]};
         4'hC: v[x] = rnd & kk;
         4'hD: begin
            v[15] = 8'h00;
            draw(a, b, n);
         end
         4'hE: begin
            if (kk == EX_SKIP_HELD) begin
               if (keys[a[3:0]]) pc = pc + 12'd2;
            end else if (kk == EX_SKIP_FREE) begin
               if (!keys[a[3:0]]) pc = pc + 12'd2;
            end else st = ST_UNDEF;
         end
         default: begin
            case (kk)
               FX_GET_DELAY: v[x] = delay_t;
               FX_KEY_WAIT: begin
                  if (kdv) v[x] = {4'd0, kcode};
                  else begin
                     pc = pc - 12'd2;
                     st = ST_WAIT;
                  end
               end
               FX_SET_DELAY: delay_t = a;
               FX_SET_SOUND: sound_t = a;
               FX_ADD_I: idx = idx + {4'd0, a};
               FX_FONT: idx = 12'(5 * a[3:0]);
               FX_BCD: begin
                  mem[idx] = a / 100;
                  mem[idx + 12'd1] = (a / 10) % 10;
                  mem[idx + 12'd2] = a % 10;
               end
               FX_STORE: for (int i = 0; i <= x; i++) mem[idx + 12'(i)] = v[i];
               FX_FETCH: for (int i = 0; i <= x; i++) v[i] = mem[idx + 12'(i)];
               default: st = ST_UNDEF;
            endcase
         end
      endcase
   endtask

   assign pending = result_queue.size();

   always @(posedge clock) begin
      core_result_type e;
      logic [2:0]      st;
      if (reset) begin
         clear_core();
         result_queue.delete();
         fail_count = 0;
      end else begin
         if (csr_write_enable) begin
            pc = csr_write_data;
         end
         if (req_valid && !req_stall) begin
            e.row = '0;
            case (req_func)
               FN_LOAD: mem[req_address] = req_load_data;
               FN_TICK: begin
                  if (delay_t != 0) delay_t--;
                  if (sound_t != 0) sound_t--;
               end
               FN_ROW: e.row = frame[req_address[4:0]];
               default: ;
            endcase
            if (req_func == FN_EXEC)
               run_instruction(req_keys_held, req_key_down_valid, req_key_down_code,
                               req_random_byte, st);
            else st = halted ? ST_HALT : ST_OK;
            e.status = st;
            e.pc = pc;
            e.sound = (sound_t != 0);
            result_queue.push_back(e);
         end
         if (rsp_valid && !rsp_stall) begin
            if (result_queue.size() == 0) begin
               $error("item on result channel with nothing expected");
               fail_count++;
            end else begin
               e = result_queue.pop_front();
               if (rsp_status !== e.status) begin
                  $error("status: expected %0d, got %0d", e.status, rsp_status);
                  fail_count++;
               end
               if (rsp_program_counter !== e.pc) begin
                  $error("program_counter: expected %h, got %h", e.pc, rsp_program_counter);
                  fail_count++;
               end
               if (rsp_sound_on !== e.sound) begin
                  $error("sound_on: expected %b, got %b", e.sound, rsp_sound_on);
                  fail_count++;
               end
               if (rsp_display_row !== e.row) begin
                  $error("display_row: expected %h, got %h", e.row, rsp_display_row);
                  fail_count++;
               end
            end
         end
      end
   end

endmodule

// File: sim/tb_chip8_instruction_core_top.sv
module tb_chip8_instruction_core_top;
   import c8_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int SETTLE = 100;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_func = FN_LOAD;
   logic [11:0] req_address = '0;
   logic [7:0]  req_load_data = '0;
   logic [15:0] req_keys_held = '0;
   logic        req_key_down_valid = 1'b0;
   logic [3:0]  req_key_down_code = '0;
   logic [7:0]  req_random_byte = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [11:0] rsp_program_counter;
   logic        rsp_sound_on;
   logic [63:0] rsp_display_row;
   logic        csr_write_enable = 1'b0;
   logic [11:0] csr_write_data = '0;

   int fail_count, pending, idle_cycles;
   logic no_idle = 1'b1;
   logic hold_off = 1'b0;

   always #4 clock = ~clock;

   chip8_instruction_core_top dut (.*);

   chip8_instruction_core_checker checker_i (.*);

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("FAIL chip8_instruction_core_top");
         $finish;
      end
   end

   // Result side: random stall per item unless no_idle; one long hold-off on request.
   initial begin
      int w;
      forever begin
         w = no_idle ? 0 : $urandom_range(0, 14);
         if (hold_off) w = 400;
         if (w > 0) begin
            @(negedge clock) rsp_stall <= 1'b1;
            repeat (w - 1) @(negedge clock);
            if (w == 400) hold_off = 1'b0;
         end
         @(negedge clock) rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // kv of 2 draws the key event at random.
   task automatic send(input logic [1:0] f, input logic [11:0] a, input logic [7:0] d,
                       input int kv);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 14);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_func <= f;
      req_address <= a;
      req_load_data <= d;
      req_keys_held <= 16'($urandom);
      req_key_down_valid <= (kv == 2) ? 1'($urandom) : 1'(kv);
      req_key_down_code <= 4'($urandom);
      req_random_byte <= 8'($urandom);
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic load_word(input logic [11:0] a, input logic [15:0] w);
      send(FN_LOAD, a, w[15:8], 2);
      send(FN_LOAD, a + 12'd1, w[7:0], 2);
   endtask

   task automatic settle_and_set_start(input logic [11:0] s);
      @(negedge clock) req_valid <= 1'b0;
      wait (pending == 0);
      repeat (SETTLE) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= s;
      @(negedge clock) csr_write_enable <= 1'b0;
   endtask

   function automatic logic [15:0] random_word(input logic [11:0] base);
      logic [3:0]  hi;
      logic [15:0] w;
      logic [7:0]  fx [9] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65};
      hi = 4'($urandom);
      w = {hi, 12'($urandom)};
      case (hi)
         4'h0: begin
            w = ($urandom_range(0, 2) != 0) ? 16'h00E0 : {4'h0, 12'($urandom)};
            // A return is kept out of random code; an empty stack would halt for good.
            if (w == 16'h00EE) w = 16'h00E0;
         end
         4'h1, 4'h2, 4'hB: w = {hi, base + 12'(2 * $urandom_range(0, 15))};
         4'h5, 4'h9: if ($urandom_range(0, 3) != 0) w[3:0] = 4'h0;
         4'hE: if ($urandom_range(0, 3) != 0) w[7:0] = $urandom_range(0, 1) ? 8'h9E : 8'hA1;
         4'hF: if ($urandom_range(0, 4) != 0) w[7:0] = fx[$urandom_range(0, 8)];
         default: ;
      endcase
      return w;
   endfunction

   initial begin
      logic [11:0] base;
      logic [15:0] prog [7];
      int r;
      prog = '{16'h60FF, 16'h6101, 16'h8014, 16'hD015,
               16'h220C, 16'hF00A, 16'h00EE};
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Directed: carry, font draw, call and return, key wait, tick and row reads.
      for (int i = 0; i < 7; i++) load_word(12'h200 + 12'(2 * i), prog[i]);
      for (int i = 0; i < 6; i++) send(FN_EXEC, 12'($urandom), 8'($urandom), 2);
      send(FN_EXEC, '0, '0, 0);
      send(FN_EXEC, '0, '0, 1);
      send(FN_TICK, '0, '0, 2);
      send(FN_ROW, 12'd1, '0, 2);
      send(FN_ROW, 12'hFFF, '0, 2);

      // Start address extremes; the fetch at the top wraps to address zero.
      settle_and_set_start(12'hFFF);
      send(FN_EXEC, '0, '0, 2);
      settle_and_set_start(12'h000);
      send(FN_EXEC, '0, '0, 2);

      for (int ph = 0; ph < 6; ph++) begin
         base = (ph == 5) ? 12'hFE0 : 12'(2 * $urandom_range(0, 2000));
         settle_and_set_start(base);
         no_idle = (ph % 3 == 0);
         for (int i = 0; i < 16; i++) load_word(base + 12'(2 * i), random_word(base));
         if (ph == 2) hold_off = 1'b1;
         for (int i = 0; i < 70; i++) begin
            r = $urandom_range(0, 19);
            if (r < 15) send(FN_EXEC, 12'($urandom), 8'($urandom), 2);
            else if (r < 17) send(FN_TICK, 12'($urandom), 8'($urandom), 2);
            else if (r < 19) send(FN_ROW, 12'($urandom), 8'($urandom), 2);
            else send(FN_LOAD, 12'($urandom), 8'($urandom), 2);
         end
      end

      // Returns until the stack runs dry and the core halts; then it must stay halted.
      no_idle = 1'b0;
      settle_and_set_start(12'h100);
      load_word(12'h100, 16'h00EE);
      for (int i = 0; i < STACK_DEPTH + 2; i++) begin
         settle_and_set_start(12'h100);
         send(FN_EXEC, '0, '0, 2);
      end
      send(FN_EXEC, '0, '0, 2);
      send(FN_LOAD, 12'h300, 8'h12, 2);
      send(FN_TICK, '0, '0, 2);
      send(FN_ROW, 12'd0, '0, 2);

      @(negedge clock) req_valid <= 1'b0;
      wait (pending == 0);
      repeat (SETTLE) @(negedge clock);
      if (fail_count == 0) $display("PASS chip8_instruction_core_top");
      else $display("FAIL chip8_instruction_core_top");
      $finish;
   end

endmodule

// File: files.f
sv/c8_pkg.sv
sv/c8_ram.sv
sv/c8_alu.sv
sv/chip8_instruction_core_top.sv
sim/chip8_instruction_core_checker.sv
sim/tb_chip8_instruction_core_top.sv
